// File: rtl/core/hcb_pkg.sv
// shared types, constants and the mod-26 reduction for the hill cipher block
package hcb_pkg;

    localparam int LETTER_W   = 5;
    localparam int KEY_W      = 15;
    localparam int BLOCK_MAX  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = 2 * LETTER_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int MOD_BASE   = 26;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_MUL  = ((1 << RECIP_SHIFT) + MOD_BASE - 1) / MOD_BASE;
    localparam int RECIP_W    = RECIP_SHIFT;
    localparam int QUOT_W     = 8;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW2   = 3'd3;

    typedef struct packed {
        logic [LETTER_W-1:0] letter_index;
        logic                message_end;
    } hcb_in_t;

    typedef struct packed {
        logic [LETTER_W-1:0] cipher_letter;
        logic                block_last;
        logic                length_error;
    } hcb_out_t;

    // one queued piece of work: a full block or a short-message error
    typedef struct packed {
        logic [BLOCK_MAX-1:0][LETTER_W-1:0] letters;
        logic                               three_mode;
        logic                               is_error;
    } hcb_job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } hcb_qstat_t;

    // reduce a row sum modulo 26 with a reciprocal multiply, exact below 2^SUM_W
    function automatic logic [LETTER_W-1:0] mod26(input logic [SUM_W-1:0] s);
        logic [SUM_W+RECIP_W-1:0] prod;
        logic [QUOT_W-1:0]        q;
        logic [SUM_W-1:0]         qm;
        logic [SUM_W-1:0]         rem;
        prod = (SUM_W + RECIP_W)'(s) * (SUM_W + RECIP_W)'(RECIP_MUL);
        q    = prod[RECIP_SHIFT +: QUOT_W];
        qm   = SUM_W'(q) * SUM_W'(MOD_BASE);
        rem  = s - qm;
        if (rem >= SUM_W'(MOD_BASE))
        begin
            rem = rem - SUM_W'(MOD_BASE);
        end
        return rem[LETTER_W-1:0];
    endfunction

endpackage

// File: rtl/core/hcb_front.sv
// front end: gathers letters into blocks and queues full blocks or length errors
module hcb_front import hcb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       block_mode,
    input  logic       fill_clear,
    input  logic       plain_valid,
    output logic       plain_stall,
    input  hcb_in_t    plain_data,
    input  hcb_qstat_t qstat,
    output logic       push,
    output hcb_job_t   push_job
);

    logic [1:0]          fill_reg, fill_next;
    logic [LETTER_W-1:0] buf_reg [BLOCK_MAX];
    logic [1:0]          size_m1;
    logic [1:0]          fill_eff;
    logic                block_done;
    logic                accept;

    assign plain_stall = qstat.full;
    assign accept      = plain_valid && !qstat.full;

    always_comb
    begin
        size_m1    = block_mode ? 2'd2 : 2'd1;
        fill_eff   = (fill_reg > size_m1) ? 2'd0 : fill_reg;
        block_done = (fill_eff == size_m1);
        push       = accept && (block_done || plain_data.message_end);

        for (int i = 0; i < BLOCK_MAX; i++)
        begin
            push_job.letters[i] = (fill_eff == 2'(i)) ? plain_data.letter_index : buf_reg[i];
        end
        push_job.three_mode = block_mode;
        push_job.is_error   = !block_done;

        fill_next = fill_reg;
        if (fill_clear)
        begin
            fill_next = 2'd0;
        end
        else if (accept)
        begin
            fill_next = (block_done || plain_data.message_end) ? 2'd0 : fill_eff + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg[fill_eff] <= plain_data.letter_index;
        end
    end

endmodule

// File: rtl/core/hcb_queue.sv
// short job queue between the front end and the back end
module hcb_queue import hcb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  hcb_job_t   push_job,
    input  logic       pop,
    output hcb_job_t   head_job,
    output hcb_qstat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hcb_job_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign qstat.empty = (cnt_reg == CNT_W'(0));
    assign qstat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign head_job    = mem[rd_reg];

    always_comb
    begin
        do_push  = push && !qstat.full;
        do_pop   = pop && !qstat.empty;
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/core/hcb_back.sv
// back end: walks the rows of each queued block, one cipher letter per cycle unless the output stalls
module hcb_back import hcb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KEY_W-1:0] key_row0,
    input  logic [KEY_W-1:0] key_row1,
    input  logic [KEY_W-1:0] key_row2,
    input  hcb_job_t         head_job,
    input  hcb_qstat_t       qstat,
    output logic             pop,
    output logic             cipher_valid,
    input  logic             cipher_stall,
    output hcb_out_t         cipher_data
);

    logic [1:0]       row_reg, row_next;
    logic             s1_valid_reg, s1_valid_next;
    logic [SUM_W-1:0] s1_sum_reg;
    logic             s1_last_reg;
    logic             s1_err_reg;
    logic             out_valid_reg, out_valid_next;
    hcb_out_t         out_reg;

    logic             out_adv;
    logic             s1_free;
    logic             issue;
    logic             last_row;
    logic [KEY_W-1:0] key_sel;
    logic [SUM_W-1:0] row_sum;

    assign out_adv      = !out_valid_reg || !cipher_stall;
    assign s1_free      = !s1_valid_reg || out_adv;
    assign issue        = !qstat.empty && s1_free;
    assign cipher_valid = out_valid_reg;
    assign cipher_data  = out_reg;

    always_comb
    begin
        case (row_reg)
            2'd0:    key_sel = key_row0;
            2'd1:    key_sel = key_row1;
            2'd2:    key_sel = key_row2;
            default: key_sel = '0;
        endcase

        // third column only takes part in 3x3 mode
        row_sum = '0;
        for (int c = 0; c < BLOCK_MAX; c++)
        begin
            if (c < BLOCK_MAX - 1 || head_job.three_mode)
            begin
                row_sum = row_sum + SUM_W'(PROD_W'(key_sel[c*LETTER_W +: LETTER_W])
                                           * PROD_W'(head_job.letters[c]));
            end
        end
        if (head_job.is_error)
        begin
            row_sum = '0;
        end

        last_row = head_job.is_error
                   || (row_reg == (head_job.three_mode ? 2'd2 : 2'd1));
        pop      = issue && last_row;

        row_next = row_reg;
        if (issue)
        begin
            row_next = last_row ? 2'd0 : row_reg + 2'd1;
        end

        s1_valid_next = s1_free ? issue : s1_valid_reg;
        out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= 2'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_sum_reg  <= row_sum;
            s1_last_reg <= last_row;
            s1_err_reg  <= head_job.is_error;
        end
        if (out_adv && s1_valid_reg)
        begin
            out_reg.cipher_letter <= mod26(s1_sum_reg);
            out_reg.block_last    <= s1_last_reg;
            out_reg.length_error  <= s1_err_reg;
        end
    end

endmodule

// File: rtl/core/hill_cipher_block_2_or_3_core.sv
// Hill cipher core over letter indices 0..25 with selectable 2x2 or 3x3 blocks.
// The block takes one letter per cycle and gives one cipher letter per cycle, so
// a steady stream runs at one item per cycle on both sides unless stalled; a
// block of n letters gives n result items, the last marked with block_last, and
// a message that ends mid-block gives a single item with length_error set. A
// full block's last letter passes the job queue, row sum register and mod-26
// output register before its first cipher letter is valid; the rest follow one
// per cycle unless stalled. The front end gathers letters and queues jobs; the
// input stalls only when the job queue (QUEUE_DEPTH jobs) is full, which
// happens when the output side has been stalled. Configuration is written
// through cfg_write, cfg_index and cfg_data while the block is idle; a write to
// block_mode drops a partial block, and indexes past the key rows are ignored.
module hill_cipher_block_2_or_3_core import hcb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data,
    input  logic                 plain_valid,
    output logic                 plain_stall,
    input  hcb_in_t              plain_data,
    output logic                 cipher_valid,
    input  logic                 cipher_stall,
    output hcb_out_t             cipher_data
);

    logic             block_mode_reg, block_mode_next;
    logic [KEY_W-1:0] key_row0_reg, key_row0_next;
    logic [KEY_W-1:0] key_row1_reg, key_row1_next;
    logic [KEY_W-1:0] key_row2_reg, key_row2_next;
    logic             fill_clear;

    logic       push;
    hcb_job_t   push_job;
    logic       pop;
    hcb_job_t   head_job;
    hcb_qstat_t qstat;

    always_comb
    begin
        block_mode_next = block_mode_reg;
        key_row0_next   = key_row0_reg;
        key_row1_next   = key_row1_reg;
        key_row2_next   = key_row2_reg;
        fill_clear      = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_BLOCK_MODE:
                begin
                    block_mode_next = cfg_data[0];
                    fill_clear      = 1'b1;
                end
                CFG_KEY_ROW0:    key_row0_next = cfg_data;
                CFG_KEY_ROW1:    key_row1_next = cfg_data;
                CFG_KEY_ROW2:    key_row2_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_mode_reg <= 1'b1;
            key_row0_reg   <= '0;
            key_row1_reg   <= '0;
            key_row2_reg   <= '0;
        end
        else
        begin
            block_mode_reg <= block_mode_next;
            key_row0_reg   <= key_row0_next;
            key_row1_reg   <= key_row1_next;
            key_row2_reg   <= key_row2_next;
        end
    end

    hcb_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .block_mode  (block_mode_reg),
        .fill_clear  (fill_clear),
        .plain_valid (plain_valid),
        .plain_stall (plain_stall),
        .plain_data  (plain_data),
        .qstat       (qstat),
        .push        (push),
        .push_job    (push_job)
    );

    hcb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    hcb_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_row0     (key_row0_reg),
        .key_row1     (key_row1_reg),
        .key_row2     (key_row2_reg),
        .head_job     (head_job),
        .qstat        (qstat),
        .pop          (pop),
        .cipher_valid (cipher_valid),
        .cipher_stall (cipher_stall),
        .cipher_data  (cipher_data)
    );

endmodule
